FILE: hw/rtl/dogc_pkg.sv
// Shared constants and codes for the disk obstacle grid clearance block.
// No dependencies; dogc_cell and the top level import it.
package dogc_pkg;

	localparam int POS_W = 24;
	localparam int RAD_W = 23;
	localparam int CS_W  = 16;
	localparam int VAL_W = 8;

	localparam int GRID_SIDE_DEF     = 64;
	localparam int MAX_OBSTACLES_DEF = 16;
	localparam int MAX_OFFSET_DEF    = 32;

	localparam logic [CS_W-1:0]         CS_RESET   = 16'd26;
	localparam logic signed [VAL_W-1:0] OCC_RESET  = 8'sd44;
	localparam logic signed [VAL_W-1:0] FREE_RESET = -8'sd44;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_CLEAR  = 2'd1,
		FN_RENDER = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_CELL_SIZE = 2'd0,
		REG_OCCUPIED  = 2'd1,
		REG_FREE      = 2'd2
	} reg_idx_t;

endpackage

FILE: hw/rtl/dogc_cell.sv
// One cell of the disk test chain: holds one disk and tests each passing
// grid point against it, three register stages deep. Depends on dogc_pkg.
module dogc_cell #(
	parameter int CW = 28,
	parameter int TW = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic signed [dogc_pkg::POS_W-1:0]  ld_x,
	input  logic signed [dogc_pkg::POS_W-1:0]  ld_y,
	input  logic [dogc_pkg::RAD_W-1:0]         ld_r,
	input  logic                               en,
	input  logic                               up_vld,
	input  logic signed [CW-1:0]               up_cx,
	input  logic signed [CW-1:0]               up_cy,
	input  logic                               up_hit,
	input  logic [TW-1:0]                      up_tag,
	output logic                               dn_vld,
	output logic signed [CW-1:0]               dn_cx,
	output logic signed [CW-1:0]               dn_cy,
	output logic                               dn_hit,
	output logic [TW-1:0]                      dn_tag
);
	import dogc_pkg::*;

	localparam int DW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int SW = 2 * DW + 1;

	logic signed [POS_W-1:0] x_q, y_q;
	logic [2*RAD_W-1:0]      rsq_q;

	logic                 vld_s1, vld_s2;
	logic signed [CW-1:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic                 hit_s1, hit_s2;
	logic [TW-1:0]        tag_s1, tag_s2;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [2*DW-1:0] xx_s2, yy_s2;
	logic [SW-1:0]        dist_sq;
	logic                 in_disk;

	assign dist_sq = SW'($unsigned(xx_s2)) + SW'($unsigned(yy_s2));
	assign in_disk = en && (dist_sq < SW'(rsq_q));

	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= ld_x;
			y_q   <= ld_y;
			rsq_q <= (2*RAD_W)'(ld_r) * (2*RAD_W)'(ld_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			dn_vld <= 1'b0;
		end else begin
			vld_s1 <= up_vld;
			vld_s2 <= vld_s1;
			dn_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1  <= up_cx;
		cy_s1  <= up_cy;
		hit_s1 <= up_hit;
		tag_s1 <= up_tag;
		dx_s1  <= DW'(up_cx) - DW'(x_q);
		dy_s1  <= DW'(up_cy) - DW'(y_q);

		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		hit_s2 <= hit_s1;
		tag_s2 <= tag_s1;
		xx_s2  <= dx_s1 * dx_s1;
		yy_s2  <= dy_s1 * dy_s1;

		dn_cx  <= cx_s2;
		dn_cy  <= cy_s2;
		dn_hit <= hit_s2 | in_disk;
		dn_tag <= tag_s2;
	end

endmodule

FILE: hw/rtl/dogc_div.sv
// Restoring divider, one quotient bit per cycle, for unsigned operands.
// Depends on no other file; used for the query index and window.
module dogc_div #(
	parameter int NW   = 28,
	parameter int DENW = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   num,
	input  logic [DENW-1:0] den,
	output logic            done,
	output logic [NW-1:0]   quo
);
	localparam int CNW = $clog2(NW + 1);

	logic            run_q;
	logic [CNW-1:0]  cnt_q;
	logic [NW-1:0]   num_q;
	logic [DENW-1:0] den_q;
	logic [DENW-1:0] rem_q;
	logic [DENW:0]   trial;
	logic [DENW:0]   diff;
	logic            ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
			quo   <= {quo[NW-2:0], ge};
			num_q <= num_q << 1;
		end
	end

endmodule

FILE: hw/rtl/disk_obstacle_grid_clearance.sv
// Top level of the disk obstacle grid clearance block.
// Depends on dogc_pkg, dogc_cell and dogc_div.
//
// Add and clear go straight from idle to the finish state. Render streams
// every grid cell, one per cycle, through a chain of MAX_OBSTACLES disk
// cells and writes the grid memory at the tail. A query first runs three
// serial divisions (row, column, window) on the shared divider, then scans
// (2k)^2 window cells one per cycle through a disk cell and the grid's read
// port, plus a short drain. The grid reads as all zero until the first
// render, so no clearing pass follows reset. One item is worked on at a
// time; the next one may be accepted while a result waits.
module disk_obstacle_grid_clearance #(
	parameter int GRID_SIDE     = dogc_pkg::GRID_SIDE_DEF,
	parameter int MAX_OBSTACLES = dogc_pkg::MAX_OBSTACLES_DEF,
	parameter int MAX_OFFSET    = dogc_pkg::MAX_OFFSET_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic signed [dogc_pkg::POS_W-1:0] pos_x,
	input  logic signed [dogc_pkg::POS_W-1:0] pos_y,
	input  logic [dogc_pkg::RAD_W-1:0]        radius,
	input  logic signed [dogc_pkg::VAL_W-1:0] threshold,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              is_clear,
	output logic [4:0]                        obstacle_count,
	output logic                              table_full,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [15:0]                       cfg_data
);
	import dogc_pkg::*;

	localparam int GW   = $clog2(GRID_SIDE);
	localparam int AW   = $clog2(GRID_SIDE * GRID_SIDE);
	localparam int CTR  = (GRID_SIDE - 1) / 2;
	localparam int IW   = GW + 1;
	localparam int CW   = CS_W + 1 + IW;
	localparam int VW   = ((POS_W > CS_W + GW) ? POS_W : CS_W + GW) + 2;
	localparam int NW   = VW + 1;
	localparam int RW   = NW + 2;
	localparam int KW   = $clog2(MAX_OFFSET + 1);
	localparam int UW   = KW + 1;
	localparam int CNTW = $clog2(MAX_OBSTACLES + 1);
	localparam int RDRN = 3 * MAX_OBSTACLES + 3;
	localparam int QDRN = 7;
	localparam int DRW  = $clog2(((RDRN > QDRN) ? RDRN : QDRN) + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIVR, ST_DIVC, ST_DIVK, ST_SCAN, ST_REND, ST_DRAIN, ST_FIN
	} state_t;

	state_t state_q;

	logic [CS_W-1:0]         cs_q;
	logic signed [VAL_W-1:0] occ_q, fre_q;
	logic [CS_W-1:0]         cs_eff;

	logic [CNTW-1:0]         cnt_q;
	logic                    rendered_q;
	logic                    blocked_q, full_q;
	logic [1:0]              func_q;
	logic signed [POS_W-1:0] px_q, py_q;
	logic [RAD_W-1:0]        rad_q;
	logic signed [VAL_W-1:0] thr_q;

	logic signed [NW:0]      row_q, col_q;
	logic [KW-1:0]           k_q;
	logic [UW-1:0]           ui_q, uj_q;
	logic [GW-1:0]           rr_q, cc_q;
	logic [DRW-1:0]          drain_q;
	logic                    div_go_q;

	logic                    accept;
	logic                    add_ld;

	// Divider operands.
	logic signed [POS_W-1:0] pos_sel;
	logic [VW-1:0]           ctr_cs;
	logic signed [VW-1:0]    vpos;
	logic [VW-1:0]           vabs;
	logic [NW-1:0]           div_num;
	logic [CS_W:0]           div_den;
	logic                    div_done;
	logic [NW-1:0]           div_quo;
	logic signed [NW:0]      idx_signed;
	logic [KW-1:0]           k_sat;
	logic [UW-1:0]           span_m1;

	// Scan issue.
	logic signed [RW-1:0]    r_full, c_full;
	logic                    q_in_grid;
	logic [GW-1:0]           iss_r, iss_c;
	logic signed [IW-1:0]    rel_r, rel_c;

	logic                    rvld_s1, qvld_s1;
	logic signed [CW-1:0]    cx_s1, cy_s1;
	logic [AW-1:0]           addr_s1;

	logic                    ch_vld [MAX_OBSTACLES+1];
	logic signed [CW-1:0]    ch_cx  [MAX_OBSTACLES+1];
	logic signed [CW-1:0]    ch_cy  [MAX_OBSTACLES+1];
	logic                    ch_hit [MAX_OBSTACLES+1];
	logic [AW-1:0]           ch_tag [MAX_OBSTACLES+1];

	logic                    q_vld, q_hit;
	logic signed [CW-1:0]    q_cx, q_cy;
	logic [AW-1:0]           q_tag;

	logic signed [VAL_W-1:0] grid_mem [GRID_SIDE*GRID_SIDE];
	logic signed [VAL_W-1:0] rd_s5;
	logic                    chk_s5;
	logic signed [VAL_W-1:0] cell_val;

	assign cs_eff    = (cs_q == '0) ? CS_W'(1) : cs_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign add_ld    = accept && (func == FN_ADD) && (cnt_q < CNTW'(MAX_OBSTACLES));

	// Query cell index: round(p / cs + C), half away from zero.
	assign pos_sel = (state_q == ST_DIVR) ? px_q : py_q;
	assign ctr_cs  = VW'(CTR) * VW'(cs_eff);
	assign vpos    = VW'(pos_sel) + $signed(ctr_cs);
	assign vabs    = vpos[VW-1] ? VW'(-vpos) : VW'(vpos);

	always_comb begin
		if (state_q == ST_DIVK) begin
			div_num = NW'(rad_q) + NW'(cs_eff) - NW'(1);
			div_den = {1'b0, cs_eff};
		end else begin
			div_num = {vabs, 1'b0} + NW'(cs_eff);
			div_den = {cs_eff, 1'b0};
		end
	end

	assign idx_signed = vpos[VW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign k_sat      = (div_quo > NW'(MAX_OFFSET)) ? KW'(MAX_OFFSET) : div_quo[KW-1:0];
	assign span_m1    = {k_q, 1'b0} - UW'(1);

	dogc_div #(
		.NW   (NW),
		.DENW (CS_W + 1)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign r_full    = RW'(row_q) + $signed(RW'(ui_q)) - $signed(RW'(k_q));
	assign c_full    = RW'(col_q) + $signed(RW'(uj_q)) - $signed(RW'(k_q));
	assign q_in_grid = (r_full >= 0) && (r_full < RW'(GRID_SIDE)) &&
	                   (c_full >= 0) && (c_full < RW'(GRID_SIDE));
	assign iss_r     = (state_q == ST_REND) ? rr_q : r_full[GW-1:0];
	assign iss_c     = (state_q == ST_REND) ? cc_q : c_full[GW-1:0];
	assign rel_r     = $signed({1'b0, iss_r}) - IW'(CTR);
	assign rel_c     = $signed({1'b0, iss_c}) - IW'(CTR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			qvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == ST_REND);
			qvld_s1 <= (state_q == ST_SCAN) && q_in_grid;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1   <= CW'($signed({1'b0, cs_eff})) * CW'(rel_r);
		cy_s1   <= CW'($signed({1'b0, cs_eff})) * CW'(rel_c);
		addr_s1 <= AW'(iss_r) * AW'(GRID_SIDE) + AW'(iss_c);
	end

	// Obstacle chain for render.
	assign ch_vld[0] = rvld_s1;
	assign ch_cx[0]  = cx_s1;
	assign ch_cy[0]  = cy_s1;
	assign ch_hit[0] = 1'b0;
	assign ch_tag[0] = addr_s1;

	for (genvar g = 0; g < MAX_OBSTACLES; g++) begin : g_chain
		dogc_cell #(
			.CW (CW),
			.TW (AW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (add_ld && (cnt_q == CNTW'(g))),
			.ld_x   (pos_x),
			.ld_y   (pos_y),
			.ld_r   (radius),
			.en     (CNTW'(g) < cnt_q),
			.up_vld (ch_vld[g]),
			.up_cx  (ch_cx[g]),
			.up_cy  (ch_cy[g]),
			.up_hit (ch_hit[g]),
			.up_tag (ch_tag[g]),
			.dn_vld (ch_vld[g+1]),
			.dn_cx  (ch_cx[g+1]),
			.dn_cy  (ch_cy[g+1]),
			.dn_hit (ch_hit[g+1]),
			.dn_tag (ch_tag[g+1])
		);
	end

	// Query disk: the same cell, loaded with the query point and radius.
	dogc_cell #(
		.CW (CW),
		.TW (AW)
	) u_qcell (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && (func == FN_QUERY)),
		.ld_x   (pos_x),
		.ld_y   (pos_y),
		.ld_r   (radius),
		.en     (1'b1),
		.up_vld (qvld_s1),
		.up_cx  (cx_s1),
		.up_cy  (cy_s1),
		.up_hit (1'b0),
		.up_tag (addr_s1),
		.dn_vld (q_vld),
		.dn_cx  (q_cx),
		.dn_cy  (q_cy),
		.dn_hit (q_hit),
		.dn_tag (q_tag)
	);

	always_ff @(posedge clk) begin
		if (ch_vld[MAX_OBSTACLES]) begin
			grid_mem[ch_tag[MAX_OBSTACLES]] <= ch_hit[MAX_OBSTACLES] ? occ_q : fre_q;
		end
		rd_s5 <= grid_mem[q_tag];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s5 <= 1'b0;
		end else begin
			chk_s5 <= q_vld && q_hit;
		end
	end

	// Before the first render every cell reads as zero; the memory has no reset.
	assign cell_val = rendered_q ? rd_s5 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q  <= CS_RESET;
			occ_q <= OCC_RESET;
			fre_q <= FREE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CELL_SIZE: cs_q  <= cfg_data;
				REG_OCCUPIED:  occ_q <= cfg_data[VAL_W-1:0];
				REG_FREE:      fre_q <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			px_q   <= pos_x;
			py_q   <= pos_y;
			rad_q  <= radius;
			thr_q  <= threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			rendered_q     <= 1'b0;
			blocked_q      <= 1'b0;
			full_q         <= 1'b0;
			row_q          <= '0;
			col_q          <= '0;
			k_q            <= '0;
			ui_q           <= '0;
			uj_q           <= '0;
			rr_q           <= '0;
			cc_q           <= '0;
			drain_q        <= '0;
			div_go_q       <= 1'b0;
			out_valid      <= 1'b0;
			is_clear       <= 1'b0;
			obstacle_count <= '0;
			table_full     <= 1'b0;
		end else begin
			div_go_q  <= (accept && (func == FN_QUERY)) ||
			             (div_done && ((state_q == ST_DIVR) || (state_q == ST_DIVC)));
			out_valid <= ((state_q == ST_FIN) && (!out_valid || out_ready)) ||
			             (out_valid && !out_ready);
			blocked_q <= accept ? 1'b0 : (blocked_q || (chk_s5 && (cell_val > thr_q)));

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						full_q <= (func == FN_ADD) && !add_ld;
						unique case (func_t'(func))
							FN_ADD: begin
								if (add_ld) begin
									cnt_q <= cnt_q + 1'b1;
								end
								state_q <= ST_FIN;
							end
							FN_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FIN;
							end
							FN_RENDER: begin
								rendered_q <= 1'b1;
								rr_q       <= '0;
								cc_q       <= '0;
								state_q    <= ST_REND;
							end
							FN_QUERY: begin
								state_q <= ST_DIVR;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_DIVR: begin
					if (div_done) begin
						row_q   <= idx_signed;
						state_q <= ST_DIVC;
					end
				end
				ST_DIVC: begin
					if (div_done) begin
						col_q   <= idx_signed;
						state_q <= ST_DIVK;
					end
				end
				ST_DIVK: begin
					if (div_done) begin
						k_q  <= k_sat;
						ui_q <= '0;
						uj_q <= '0;
						if (k_sat == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (uj_q == span_m1) begin
						uj_q <= '0;
						ui_q <= ui_q + 1'b1;
						if (ui_q == span_m1) begin
							drain_q <= DRW'(QDRN);
							state_q <= ST_DRAIN;
						end
					end else begin
						uj_q <= uj_q + 1'b1;
					end
				end
				ST_REND: begin
					if (cc_q == GW'(GRID_SIDE - 1)) begin
						cc_q <= '0;
						rr_q <= rr_q + 1'b1;
						if (rr_q == GW'(GRID_SIDE - 1)) begin
							drain_q <= DRW'(RDRN);
							state_q <= ST_DRAIN;
						end
					end else begin
						cc_q <= cc_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid || out_ready) begin
						is_clear       <= (func_q == FN_QUERY) && !blocked_q;
						obstacle_count <= 5'(cnt_q);
						table_full     <= full_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
